// File: sv/urcb_pkg.sv
// ============================================================================
// urcb_pkg
// Shared types and constants for the undo/redo character buffer.
// ============================================================================
package urcb_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int CHAR_W    = 8;
    localparam int CMD_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_UNDO  = 2'd1,
        CMD_REDO  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last;
        logic              text_empty;
        logic              nothing_moved;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } fifo_stat_t;

endpackage

// File: sv/urcb_if.sv
// ============================================================================
// urcb_if
// Valid/ready channels for commands and readout beats.
// ============================================================================
interface urcb_cmd_if
    import urcb_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output command, output char_in, input ready);
    modport sink   (input valid, input command, input char_in, output ready);
endinterface

interface urcb_res_if
    import urcb_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    logic              last;
    logic              text_empty;
    logic              nothing_moved;

    modport source (output valid, output char_out, output last, output text_empty,
                    output nothing_moved, input ready);
    modport sink   (input valid, input char_out, input last, input text_empty,
                    input nothing_moved, output ready);
endinterface

// File: sv/undo_redo_char_buffer_core.sv
// ============================================================================
// undo_redo_char_buffer_core
// Character text buffer with undo and redo kept as two stacks in RAM.
// ============================================================================
// A write produces no beat. An undo or redo is accepted in idle, moves a
// character between the two stack RAMs in a move step when there is one to
// move, then reads the text out at one character per cycle while the output
// queue has room, through the text RAM read port into a two-entry output
// queue; an empty text gives one beat. A new command is taken once the last
// readout read has been issued. Writes are dropped once both stacks together
// hold DEPTH chars.
module undo_redo_char_buffer_core
    import urcb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    urcb_cmd_if.sink   cmd,
    urcb_res_if.source res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] text_cnt_reg, text_cnt_next;
    logic [CW-1:0] redo_cnt_reg, redo_cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          moved_reg, moved_next;
    logic          dir_reg, dir_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          rd_last_reg, rd_last_next;

    logic              t_we, r_we;
    logic [AW-1:0]     t_waddr, t_raddr, r_waddr, r_raddr;
    logic [CHAR_W-1:0] t_wdata, t_rdata, r_wdata, r_rdata;

    logic          push, direct;
    res_t          push_data;
    fifo_stat_t    stat;

    logic [CW:0]   sum_cnt;
    logic [CW-1:0] tc_m1, rc_m1;
    logic          can_write, can_undo, can_redo;
    logic          room, idx_is_last;
    logic [2:0]    occ;
    cmd_t          cmd_code;

    assign cmd_code    = cmd_t'(cmd.command);
    assign sum_cnt     = {1'b0, text_cnt_reg} + {1'b0, redo_cnt_reg};
    assign tc_m1       = text_cnt_reg - 1'b1;
    assign rc_m1       = redo_cnt_reg - 1'b1;
    assign can_write   = sum_cnt < (CW+1)'(DEPTH);
    assign can_undo    = (text_cnt_reg != '0) && (redo_cnt_reg < CW'(DEPTH));
    assign can_redo    = (redo_cnt_reg != '0) && (text_cnt_reg < CW'(DEPTH));
    assign occ         = 3'(stat.count) + 3'(rd_pend_reg) - 3'(stat.pop);
    assign room        = occ <= 3'd1;
    assign idx_is_last = (CW'(idx_reg) + 1'b1) == text_cnt_reg;
    assign cmd.ready   = (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd_code)
                        CMD_UNDO: state_next = can_undo ? ST_MOVE : ST_READ;
                        CMD_REDO: state_next = can_redo ? ST_MOVE : ST_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MOVE:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (room && ((text_cnt_reg == '0) || idx_is_last))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        text_cnt_next = text_cnt_reg;
        redo_cnt_next = redo_cnt_reg;
        idx_next      = idx_reg;
        moved_next    = moved_reg;
        dir_next      = dir_reg;
        rd_pend_next  = 1'b0;
        rd_last_next  = rd_last_reg;
        t_we          = 1'b0;
        t_waddr       = text_cnt_reg[AW-1:0];
        t_wdata       = cmd.char_in;
        t_raddr       = idx_reg;
        r_we          = 1'b0;
        r_waddr       = redo_cnt_reg[AW-1:0];
        r_wdata       = t_rdata;
        r_raddr       = rc_m1[AW-1:0];
        direct        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd_code)
                        CMD_WRITE:
                        begin
                            if (can_write)
                            begin
                                t_we          = 1'b1;
                                text_cnt_next = text_cnt_reg + 1'b1;
                            end
                        end
                        CMD_UNDO:
                        begin
                            moved_next = !can_undo;
                            dir_next   = 1'b1;
                            t_raddr    = tc_m1[AW-1:0];
                            idx_next   = '0;
                        end
                        CMD_REDO:
                        begin
                            moved_next = !can_redo;
                            dir_next   = 1'b0;
                            idx_next   = '0;
                        end
                        default:
                        begin
                            idx_next = idx_reg;
                        end
                    endcase
                end
            end
            ST_MOVE:
            begin
                if (dir_reg)
                begin
                    r_we          = 1'b1;
                    r_wdata       = t_rdata;
                    text_cnt_next = text_cnt_reg - 1'b1;
                    redo_cnt_next = redo_cnt_reg + 1'b1;
                end
                else
                begin
                    t_we          = 1'b1;
                    t_wdata       = r_rdata;
                    text_cnt_next = text_cnt_reg + 1'b1;
                    redo_cnt_next = redo_cnt_reg - 1'b1;
                end
            end
            ST_READ:
            begin
                if (room)
                begin
                    if (text_cnt_reg == '0)
                    begin
                        direct = 1'b1;
                    end
                    else
                    begin
                        rd_pend_next = 1'b1;
                        rd_last_next = idx_is_last;
                        idx_next     = idx_is_last ? '0 : idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_comb
    begin
        push = rd_pend_reg || direct;
        if (direct)
        begin
            push_data = '{char_out: '0, last: 1'b1, text_empty: 1'b1,
                          nothing_moved: moved_reg};
        end
        else
        begin
            push_data = '{char_out: t_rdata, last: rd_last_reg, text_empty: 1'b0,
                          nothing_moved: moved_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            text_cnt_reg <= '0;
            redo_cnt_reg <= '0;
            idx_reg      <= '0;
            moved_reg    <= 1'b0;
            dir_reg      <= 1'b0;
            rd_pend_reg  <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            text_cnt_reg <= text_cnt_next;
            redo_cnt_reg <= redo_cnt_next;
            idx_reg      <= idx_next;
            moved_reg    <= moved_next;
            dir_reg      <= dir_next;
            rd_pend_reg  <= rd_pend_next;
            rd_last_reg  <= rd_last_next;
        end
    end

    urcb_ram #(
        .WIDTH  (CHAR_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_text_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    urcb_ram #(
        .WIDTH  (CHAR_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_redo_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    urcb_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .stat      (stat),
        .res       (res)
    );

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_cnt <= (CW+1)'(DEPTH))
        else $error("stack counts exceed depth");

    a_move_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE) |-> ($past(state_reg) == ST_IDLE))
        else $error("move step not entered from idle");

    a_read_from_readout: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> ($past(state_reg) == ST_READ))
        else $error("readout beat without readout state");

endmodule

// File: sv/urcb_ram.sv
// ============================================================================
// urcb_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module urcb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/urcb_out_fifo.sv
// ============================================================================
// urcb_out_fifo
// Two-entry output queue decoupling the readout from the result channel.
// ============================================================================
module urcb_out_fifo
    import urcb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  res_t       push_data,
    output fifo_stat_t stat,
    urcb_res_if.source res
);

    res_t       ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;
    res_t       head;

    assign head              = ent_reg[rd_ptr_reg];
    assign res.valid         = (cnt_reg != 2'd0);
    assign res.char_out      = head.char_out;
    assign res.last          = head.last;
    assign res.text_empty    = head.text_empty;
    assign res.nothing_moved = head.nothing_moved;
    assign pop               = res.valid && res.ready;
    assign stat.count        = cnt_reg;
    assign stat.pop          = pop;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && (cnt_reg == 2'd2) && !pop))
        else $error("output queue overflow");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.text_empty) |-> res.last)
        else $error("empty-text beat not marked last");

endmodule
